/* sv/sfcr_pkg.sv */
// Shared types and constants for the sync framed command receiver.
// No dependencies; every other file of the block imports this package.
package sfcr_pkg;

  localparam int unsigned PayloadBytes = 20;
  localparam int unsigned WordCount    = 5;
  localparam int unsigned WordWidth    = 32;
  localparam int unsigned CountWidth   = $clog2(PayloadBytes);
  localparam int unsigned AddrWidth    = 4;
  localparam int unsigned ApbDataWidth = 32;

  localparam logic [7:0] TimeoutReset    = 8'd100;
  localparam logic [7:0] SyncFirstReset  = 8'h55;
  localparam logic [7:0] SyncSecondReset = 8'hAA;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegTimeout    = 2'd0;
  localparam logic [1:0] RegSyncFirst  = 2'd1;
  localparam logic [1:0] RegSyncSecond = 2'd2;

  // Item kinds carried on the input tuser.
  localparam logic FuncByte = 1'b0;
  localparam logic FuncPoll = 1'b1;

  typedef struct packed {
    logic [7:0] timeout_polls;
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

  typedef struct packed {
    logic                                ready;
    logic [WordCount-1:0][WordWidth-1:0] words;
  } frame_t;

endpackage

/* sv/sync_framed_command_receiver.sv */
// Top level of the sync framed command receiver: input register and glue.
// Depends on sfcr_pkg, sfcr_cfg_regs, sfcr_deframer and sfcr_poll.
//
// Channel   Direction  Content
// s_axis    in         tdata: rx_value; tuser: func (0 byte, 1 poll)
// m_axis    out        tdata: commands and status; tuser: fresh
// apb       in/out     timeout_polls, sync_first, sync_second at 0x0, 0x4, 0x8
//
// Every item passes through the input register, and a poll's result is written into
// the output register at the edge on which the poll leaves the input register.
// One item is accepted per cycle; only a poll waiting behind a held result
// stalls the input. Reset restores the registers and hunts for a sync word.
module sync_framed_command_receiver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // rx_value
  input  logic                                s_axis_tuser,  // func
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // forward_cmd, turn_cmd, pitch_cmd, roll_cmd, activate
  output logic [4*sfcr_pkg::WordWidth+7:0]    m_axis_tdata,
  output logic                                m_axis_tuser,  // fresh
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfcr_pkg::AddrWidth-1:0]      paddr,
  input  logic [sfcr_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [sfcr_pkg::ApbDataWidth-1:0]   prdata,
  output logic                                pready
);
  import sfcr_pkg::*;

  cfg_t       cfg;
  frame_t     frame;
  logic       in_valid_q, in_valid_d;
  logic       in_func_q;
  logic [7:0] in_rx_q;
  logic       stall;
  logic       advance;
  logic       in_xfer;

  assign advance       = in_valid_q & ((in_func_q == FuncByte) | ~stall);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign in_valid_d    = in_xfer | (in_valid_q & ~advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_func_q <= s_axis_tuser;
      in_rx_q   <= s_axis_tdata;
    end
  end

  sfcr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfcr_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (advance & (in_func_q == FuncByte)),
    .rx_i      (in_rx_q),
    .poll_en_i (advance & (in_func_q == FuncPoll)),
    .cfg_i     (cfg),
    .frame_o   (frame)
  );

  sfcr_poll u_poll (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .poll_en_i     (advance & (in_func_q == FuncPoll)),
    .frame_i       (frame),
    .timeout_i     (cfg.timeout_polls),
    .stall_o       (stall),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* sv/sfcr_cfg_regs.sv */
// APB configuration registers of the sync framed command receiver.
// Depends on sfcr_pkg for the register indexes and the cfg_t bundle.
module sfcr_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfcr_pkg::AddrWidth-1:0]    paddr,
  input  logic [sfcr_pkg::ApbDataWidth-1:0] pwdata,
  output logic [sfcr_pkg::ApbDataWidth-1:0] prdata,
  output logic                              pready,
  output sfcr_pkg::cfg_t                    cfg_o
);
  import sfcr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegTimeout:    cfg_d.timeout_polls = pwdata[7:0];
        RegSyncFirst:  cfg_d.sync_first    = pwdata[7:0];
        RegSyncSecond: cfg_d.sync_second   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegTimeout:    prdata = {{(ApbDataWidth-8){1'b0}}, cfg_q.timeout_polls};
      RegSyncFirst:  prdata = {{(ApbDataWidth-8){1'b0}}, cfg_q.sync_first};
      RegSyncSecond: prdata = {{(ApbDataWidth-8){1'b0}}, cfg_q.sync_second};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_polls <= TimeoutReset;
      cfg_q.sync_first    <= SyncFirstReset;
      cfg_q.sync_second   <= SyncSecondReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/sfcr_deframer.sv */
// Sync word hunter, payload collector and frame latch.
// Depends on sfcr_pkg for frame sizes and the cfg_t and frame_t bundles.
module sfcr_deframer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_en_i,
  input  logic [7:0]       rx_i,
  input  logic             poll_en_i,
  input  sfcr_pkg::cfg_t   cfg_i,
  output sfcr_pkg::frame_t frame_o
);
  import sfcr_pkg::*;

  typedef enum logic [2:0] {
    PhHunt    = 3'b001,
    PhSecond  = 3'b010,
    PhCollect = 3'b100
  } phase_e;

  phase_e                              phase_q, phase_d;
  logic [CountWidth-1:0]               cnt_q, cnt_d;
  logic [PayloadBytes-2:0][7:0]        shift_q, shift_d;
  logic [WordCount-1:0][WordWidth-1:0] words_q, words_d;
  logic                                ready_q, ready_d;
  logic [PayloadBytes-1:0][7:0]        frame_bytes;

  // The last payload byte is taken straight from the input.
  assign frame_bytes = {rx_i, shift_q};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    words_d = words_q;
    ready_d = ready_q;
    if (poll_en_i) begin
      ready_d = 1'b0;
    end
    if (byte_en_i) begin
      unique case (phase_q)
        PhSecond: begin
          if (rx_i == cfg_i.sync_second) begin
            phase_d = PhCollect;
            cnt_d   = '0;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhCollect: begin
          if (cnt_q == CountWidth'(PayloadBytes - 1)) begin
            words_d = frame_bytes;
            ready_d = 1'b1;
            phase_d = PhHunt;
          end else begin
            shift_d = {rx_i, shift_q[PayloadBytes-2:1]};
            cnt_d   = cnt_q + CountWidth'(1);
          end
        end
        default: begin
          phase_d = (rx_i == cfg_i.sync_first) ? PhSecond : PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cnt_q   <= '0;
      words_q <= '0;
      ready_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      words_q <= words_d;
      ready_q <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign frame_o.ready = ready_q;
  assign frame_o.words = words_q;

endmodule

/* sv/sfcr_poll.sv */
// Poll responder: inactivity count, status conversion and result register.
// Depends on sfcr_pkg for the frame_t bundle and word sizes.
module sfcr_poll (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             poll_en_i,
  input  sfcr_pkg::frame_t frame_i,
  input  logic [7:0]       timeout_i,
  output logic             stall_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [4*sfcr_pkg::WordWidth+7:0] m_axis_tdata,
  output logic             m_axis_tuser
);
  import sfcr_pkg::*;

  logic                         valid_q, valid_d;
  logic [4*WordWidth+7:0]       data_q, data_d;
  logic                         user_q, user_d;
  logic [7:0]                   idle_q, idle_d;
  logic [7:0]                   conv;
  logic [7:0]                   status;

  function automatic logic [7:0] to_status(logic [WordWidth-1:0] bits);
    logic [7:0]  expo;
    logic [22:0] mant;
    logic [7:0]  diff;
    logic [23:0] sig;
    logic [4:0]  shamt;
    logic [23:0] shifted;
    logic [7:0]  res;
    expo    = bits[30:23];
    mant    = bits[22:0];
    diff    = expo - 8'd127;
    sig     = {1'b1, mant};
    shamt   = 5'd23 - {2'b00, diff[2:0]};
    shifted = sig >> shamt;
    if (expo == 8'hFF && mant != '0) begin
      res = 8'd0;
    end else if (bits[31]) begin
      res = 8'd0;
    end else if (expo < 8'd127) begin
      res = 8'd0;
    end else if (expo >= 8'd135) begin
      res = 8'd255;
    end else begin
      res = shifted[7:0];
    end
    return res;
  endfunction

  assign conv    = to_status(frame_i.words[4]);
  assign stall_o = valid_q & ~m_axis_tready;

  always_comb begin
    idle_d  = idle_q;
    valid_d = valid_q & ~m_axis_tready;
    data_d  = data_q;
    user_d  = user_q;
    status  = conv;
    if (!frame_i.ready && idle_q >= timeout_i) begin
      status = 8'd0;
    end
    if (poll_en_i) begin
      valid_d = 1'b1;
      user_d  = frame_i.ready;
      data_d  = {status, frame_i.words[3], frame_i.words[2],
                 frame_i.words[1], frame_i.words[0]};
      if (frame_i.ready) begin
        idle_d = '0;
      end else if (idle_q != 8'hFF) begin
        idle_d = idle_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idle_q  <= '0;
    end else begin
      valid_q <= valid_d;
      idle_q  <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    user_q <= user_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

endmodule

/* tb/tb_sync_framed_command_receiver.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sync_framed_command_receiver: a directed table of expected
// replies, then random framed byte streams and polls with random idling, checked against a
// local predictor. Depends on sfcr_pkg and the block's RTL; reads no files.
module tb_sync_framed_command_receiver;
  import sfcr_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldCycles  = 300;

  typedef enum logic [1:0] {HuntFirst, AwaitSecond, Collect} deframe_e;

  typedef struct packed {
    logic        fresh;
    logic [31:0] forward;
    logic [31:0] turn;
    logic [31:0] pitch;
    logic [31:0] roll;
    logic [7:0]  activate;
  } poll_reply_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  rx;
    logic        typed;
    poll_reply_t want;
  } rx_item_t;

  localparam poll_reply_t NoReply      = '0;
  localparam poll_reply_t ResetReply   = '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h00};
  localparam poll_reply_t ExtremeReply =
    '{1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 8'hFF};
  localparam poll_reply_t StaleReply   =
    '{1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 8'hFF};

  // The second first-sync byte lands on the second-sync check and is not looked at again,
  // so only the third one starts the frame. Payload words: NaN, zero, negative zero,
  // infinity, and 256.0 as the status word.
  localparam rx_item_t DirTab [27] = '{
    '{FuncPoll, 8'hFF, 1'b1, ResetReply},
    '{FuncByte, SyncFirstReset, 1'b0, NoReply},
    '{FuncByte, SyncFirstReset, 1'b0, NoReply},
    '{FuncByte, SyncFirstReset, 1'b0, NoReply},
    '{FuncByte, SyncSecondReset, 1'b0, NoReply},
    '{FuncByte, 8'hFF, 1'b0, NoReply},
    '{FuncByte, 8'hFF, 1'b0, NoReply},
    '{FuncByte, 8'hFF, 1'b0, NoReply},
    '{FuncByte, 8'hFF, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h80, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h80, 1'b0, NoReply},
    '{FuncByte, 8'h7F, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h00, 1'b0, NoReply},
    '{FuncByte, 8'h80, 1'b0, NoReply},
    '{FuncByte, 8'h43, 1'b0, NoReply},
    '{FuncPoll, 8'h00, 1'b1, ExtremeReply},
    '{FuncPoll, 8'hA5, 1'b1, StaleReply}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [4*WordWidth+7:0]        m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [AddrWidth-1:0]          paddr;
  logic [ApbDataWidth-1:0]       pwdata;
  logic [ApbDataWidth-1:0]       prdata;
  logic                          pready;

  sync_framed_command_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state and configuration.
  cfg_t        cfg;
  deframe_e    phase;
  logic [4:0]  pay_cnt;
  logic [7:0]  pay_buf [PayloadBytes];
  logic [31:0] latched [WordCount];
  logic        frame_ready;
  logic [7:0]  idle_polls;

  rx_item_t    stim_q [$];
  rx_item_t    offered_q [$];
  poll_reply_t replies_q [$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_fresh;
  int unsigned n_blanked;
  int unsigned hold_left;
  bit          src_calm;
  bit          sink_calm;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic reset_predictor();
    cfg         = '{TimeoutReset, SyncFirstReset, SyncSecondReset};
    phase       = HuntFirst;
    pay_cnt     = '0;
    frame_ready = 1'b0;
    idle_polls  = '0;
    for (int w = 0; w < WordCount; w++) latched[w] = '0;
  endtask

  function automatic logic [7:0] float_to_status(input logic [31:0] bits);
    logic [7:0]  ex;
    logic [23:0] sig;
    ex  = bits[30:23];
    sig = {1'b1, bits[22:0]};
    if (ex == 8'hFF && bits[22:0] != '0) return 8'h00;
    if (bits[31]) return 8'h00;
    if (ex < 8'd127) return 8'h00;
    if (ex >= 8'd135) return 8'hFF;
    return 8'(sig >> (8'd150 - ex));
  endfunction

  // Advances the predictor by one accepted item; returns 1 when a poll reply is due.
  function automatic bit deframe_and_poll(input logic func, input logic [7:0] rx,
                                          output poll_reply_t reply);
    int unsigned w;
    reply = '0;
    if (func == FuncByte) begin
      case (phase)
        AwaitSecond: begin
          if (rx == cfg.sync_second) begin
            phase   = Collect;
            pay_cnt = '0;
          end else begin
            phase = HuntFirst;
          end
        end
        Collect: begin
          pay_buf[pay_cnt] = rx;
          pay_cnt++;
          if (pay_cnt == PayloadBytes) begin
            for (w = 0; w < WordCount; w++) begin
              latched[w] = {pay_buf[4*w+3], pay_buf[4*w+2], pay_buf[4*w+1], pay_buf[4*w]};
            end
            frame_ready = 1'b1;
            phase       = HuntFirst;
          end
        end
        default: phase = (rx == cfg.sync_first) ? AwaitSecond : HuntFirst;
      endcase
      return 1'b0;
    end
    reply.fresh   = frame_ready;
    reply.forward = latched[0];
    reply.turn    = latched[1];
    reply.pitch   = latched[2];
    reply.roll    = latched[3];
    if (frame_ready) begin
      frame_ready    = 1'b0;
      idle_polls     = '0;
      reply.activate = float_to_status(latched[4]);
    end else begin
      if (idle_polls < cfg.timeout_polls) begin
        reply.activate = float_to_status(latched[4]);
      end else begin
        reply.activate = 8'h00;
        n_blanked++;
      end
      if (idle_polls != 8'hFF) idle_polls++;
    end
    return 1'b1;
  endfunction

  // Transfers are recognised at the falling edge before the rising edge that completes them,
  // where every signal is stable.
  always @(negedge clk_i) begin : check_p
    poll_reply_t got;
    poll_reply_t want;
    poll_reply_t pred;
    rx_item_t    item;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.fresh    = m_axis_tuser;
        got.forward  = m_axis_tdata[0 +: 32];
        got.turn     = m_axis_tdata[32 +: 32];
        got.pitch    = m_axis_tdata[64 +: 32];
        got.roll     = m_axis_tdata[96 +: 32];
        got.activate = m_axis_tdata[128 +: 8];
        if (replies_q.size() == 0) begin
          report_mismatch("unexpected result", {31'b0, got.fresh}, 32'b0);
        end else begin
          want = replies_q.pop_front();
          if (got.fresh !== want.fresh)
            report_mismatch("fresh", {31'b0, got.fresh}, {31'b0, want.fresh});
          if (got.forward !== want.forward)
            report_mismatch("forward_cmd", got.forward, want.forward);
          if (got.turn !== want.turn) report_mismatch("turn_cmd", got.turn, want.turn);
          if (got.pitch !== want.pitch) report_mismatch("pitch_cmd", got.pitch, want.pitch);
          if (got.roll !== want.roll) report_mismatch("roll_cmd", got.roll, want.roll);
          if (got.activate !== want.activate)
            report_mismatch("activate", {24'b0, got.activate}, {24'b0, want.activate});
          n_checked++;
          if (want.fresh) n_fresh++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item = offered_q.pop_front();
        if (deframe_and_poll(item.func, item.rx, pred)) begin
          replies_q.push_back(item.typed ? item.want : pred);
        end
        n_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Run stopped by the watchdog after %0d cycles.", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, with one long hold-off counted down here.
  initial begin : sink_p
    int unsigned gap;
    bit          seen;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        while (hold_left != 0) begin
          @(posedge clk_i);
          hold_left--;
        end
      end else begin
        if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
        gap = sink_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        seen = m_axis_tvalid;
        @(posedge clk_i);
      end while (!seen && hold_left == 0);
    end
  end

  task automatic offer(input rx_item_t item);
    int unsigned gap;
    bit          rdy;
    gap = src_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered_q.push_back(item);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item.rx;
    s_axis_tuser  <= item.func;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic send_all(input bit steady);
    foreach (stim_q[i]) begin
      if (steady) src_calm = 1'b1;
      else if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
      offer(stim_q[i]);
    end
    s_axis_tvalid <= 1'b0;
    src_calm = 1'b0;
  endtask

  task automatic settle();
    while (replies_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegTimeout:    cfg.timeout_polls = value;
      RegSyncFirst:  cfg.sync_first    = value;
      RegSyncSecond: cfg.sync_second   = value;
      default: ;
    endcase
  endtask

  task automatic add_byte(input logic [7:0] rx);
    stim_q.push_back('{FuncByte, rx, 1'b0, NoReply});
  endtask

  task automatic add_poll();
    stim_q.push_back('{FuncPoll, 8'($urandom), 1'b0, NoReply});
  endtask

  // Status words spread over the interesting conversion ranges.
  function automatic logic [31:0] shaped_status_word();
    logic [22:0] m;
    m = 23'($urandom);
    case ($urandom_range(0, 7))
      0:       return {1'b0, 8'hFF, 23'h0};
      1:       return {1'($urandom), 8'hFF, m | 23'd1};
      2:       return {1'b1, 8'($urandom_range(120, 140)), m};
      3:       return $urandom;
      default: return {1'b0, 8'($urandom_range(118, 137)), m};
    endcase
  endfunction

  // Mostly well-formed frames with random payloads, mixed with polls, broken sync words,
  // truncated frames and stray bytes.
  task automatic build_random(input int unsigned count);
    int unsigned pick;
    int unsigned k;
    logic [31:0] w;
    stim_q.delete();
    while (stim_q.size() < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_byte(cfg.sync_first);
        add_byte(cfg.sync_second);
        for (int unsigned i = 0; i < WordCount; i++) begin
          w = (i == WordCount - 1) ? shaped_status_word() : $urandom;
          for (k = 0; k < 4; k++) add_byte(w[8*k +: 8]);
        end
        if ($urandom_range(0, 9) < 7) add_poll();
      end else if (pick < 72) begin
        add_poll();
      end else if (pick < 82) begin
        add_byte(cfg.sync_first);
        add_byte(8'($urandom));
      end else if (pick < 90) begin
        add_byte(cfg.sync_first);
        add_byte(cfg.sync_second);
        repeat ($urandom_range(1, PayloadBytes - 1)) add_byte(8'($urandom));
      end else begin
        add_byte(8'($urandom));
      end
    end
  endtask

  initial begin : main_p
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FuncByte;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    errors    = 0;
    cycles    = 0;
    hold_left = 0;
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    reset_predictor();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stim_q.delete();
    foreach (DirTab[i]) stim_q.push_back(DirTab[i]);
    send_all(1'b0);
    settle();

    build_random(180);
    send_all(1'b0);
    settle();

    reg_write(RegTimeout, 8'd3);
    reg_write(RegSyncFirst, 8'h00);
    reg_write(RegSyncSecond, 8'hFF);
    build_random(180);
    send_all(1'b0);
    settle();

    reg_write(RegTimeout, 8'd0);
    reg_write(RegSyncFirst, 8'hFF);
    reg_write(RegSyncSecond, 8'h00);
    build_random(120);
    send_all(1'b0);
    settle();

    reg_write(RegTimeout, 8'hFF);
    reg_write(RegSyncFirst, 8'h3C);
    reg_write(RegSyncSecond, 8'h3C);
    build_random(80);
    send_all(1'b0);

    // A long run of polls against a stalled result side: the block fills up, and the
    // idle count runs into saturation at the largest timeout.
    stim_q.delete();
    repeat (270) add_poll();
    hold_left = HoldCycles;
    send_all(1'b1);
    settle();

    $display("Accepted %0d items and checked %0d poll results, %0d of them on a fresh frame.",
             n_accepted, n_checked, n_fresh);
    $display("Status was forced to zero by the inactivity timeout %0d times.", n_blanked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
